// ===== sv/eld_pkg.sv =====
package eld_pkg;

   // one input transaction
   typedef struct packed {
      logic [7:0] log_byte;
      logic       stream_start;
   } req_type;

   // one result transaction
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  text_byte;
      logic [7:0]  source_code;
      logic [15:0] half_ms_count;
      logic [15:0] can_id;
      logic [63:0] can_payload;
      logic [7:0]  can_length;
   } rsp_type;

   // result from the parser to the output buffer
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   // result kinds
   localparam logic [2:0] KIND_TEXT     = 3'd0;
   localparam logic [2:0] KIND_TIME     = 3'd1;
   localparam logic [2:0] KIND_CAN      = 3'd2;
   localparam logic [2:0] KIND_BAD_TIME = 3'd3;
   localparam logic [2:0] KIND_BAD_CAN  = 3'd4;
   localparam logic [2:0] KIND_RAW      = 3'd5;

   // framing bytes
   localparam logic [7:0] SOH_BYTE = 8'h01;
   localparam logic [7:0] STX_BYTE = 8'h02;
   localparam logic [7:0] ETX_BYTE = 8'h03;
   localparam logic [7:0] EOT_BYTE = 8'h04;

   // parser modes
   localparam logic [1:0] MODE_TEXT = 2'd0;
   localparam logic [1:0] MODE_TIME = 2'd1;
   localparam logic [1:0] MODE_CAN  = 2'd2;

   // byte positions inside a record
   localparam logic [3:0] POS_FIRST      = 4'd0;
   localparam logic [3:0] POS_SECOND     = 4'd1;
   localparam logic [3:0] POS_THIRD      = 4'd2;
   localparam logic [3:0] TIME_CLOSE_POS = 4'd3;
   localparam logic [3:0] CAN_SIZE_POS   = 4'd10;
   localparam logic [3:0] CAN_CLOSE_POS  = 4'd11;

endpackage

// ===== sv/eld_parser.sv =====
module eld_parser import eld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req_data,
   input  logic       decode_enable,
   output result_type result
);

   logic [1:0]  mode_ff, mode_in, mode_cur;
   logic [3:0]  index_ff, index_in, index_cur;
   logic [7:0]  held_source_ff, held_source_in;
   logic [15:0] held_time_ff, held_time_in;
   logic [15:0] held_id_ff, held_id_in;
   logic [7:0]  held_data_ff [8];
   logic [7:0]  held_size_ff, held_size_in;
   logic        data_we;
   logic [2:0]  data_lane;
   logic [63:0] payload;
   logic [7:0]  b;

   assign b         = req_data.log_byte;
   assign mode_cur  = req_data.stream_start ? MODE_TEXT : mode_ff;
   assign index_cur = req_data.stream_start ? POS_FIRST : index_ff;
   assign data_lane = 3'(index_cur - POS_THIRD);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         payload[8*i +: 8] = held_data_ff[i];
      end
   end

   always_comb begin
      mode_in        = mode_cur;
      index_in       = index_cur;
      held_source_in = held_source_ff;
      held_time_in   = held_time_ff;
      held_id_in     = held_id_ff;
      held_size_in   = held_size_ff;
      data_we        = 1'b0;
      result         = '0;
      if (!decode_enable) begin
         result.valid          = 1'b1;
         result.data.kind      = KIND_RAW;
         result.data.text_byte = b;
      end else begin
         case (mode_cur)
            MODE_TEXT: begin
               index_in = POS_FIRST;
               if (b == SOH_BYTE) begin
                  mode_in = MODE_CAN;
               end else if (b == STX_BYTE) begin
                  mode_in = MODE_TIME;
               end else begin
                  result.valid          = 1'b1;
                  result.data.kind      = KIND_TEXT;
                  result.data.text_byte = b;
               end
            end
            MODE_TIME: begin
               index_in = index_cur + 4'd1;
               if (index_cur == POS_FIRST) begin
                  held_source_in = b;
               end else if (index_cur == POS_SECOND) begin
                  held_time_in = {8'd0, b};
               end else if (index_cur == POS_THIRD) begin
                  held_time_in = {held_time_ff[7:0], b};
               end else begin
                  mode_in      = MODE_TEXT;
                  result.valid = 1'b1;
                  if (b != ETX_BYTE) begin
                     result.data.kind = KIND_BAD_TIME;
                  end else begin
                     result.data.kind          = KIND_TIME;
                     result.data.source_code   = held_source_ff;
                     result.data.half_ms_count = held_time_ff;
                  end
               end
            end
            MODE_CAN: begin
               index_in = index_cur + 4'd1;
               if (index_cur == POS_FIRST) begin
                  held_id_in = {8'd0, b};
               end else if (index_cur == POS_SECOND) begin
                  held_id_in = {held_id_ff[7:0], b};
               end else if (index_cur < CAN_SIZE_POS) begin
                  data_we = 1'b1;
               end else if (index_cur == CAN_SIZE_POS) begin
                  held_size_in = b;
               end else begin
                  mode_in      = MODE_TEXT;
                  result.valid = 1'b1;
                  if (b != EOT_BYTE) begin
                     result.data.kind = KIND_BAD_CAN;
                  end else begin
                     result.data.kind        = KIND_CAN;
                     result.data.can_id      = held_id_ff;
                     result.data.can_payload = payload;
                     result.data.can_length  = held_size_ff;
                  end
               end
            end
            default: begin
               // unused mode swallows the byte
               mode_in = MODE_TEXT;
            end
         endcase
      end
      result.valid = result.valid & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TEXT;
         index_ff <= POS_FIRST;
      end else if (accept) begin
         mode_ff  <= mode_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_source_ff <= held_source_in;
         held_time_ff   <= held_time_in;
         held_id_ff     <= held_id_in;
         held_size_ff   <= held_size_in;
         if (data_we) begin
            held_data_ff[data_lane] <= b;
         end
      end
   end

   a_time_index: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_TIME |-> index_ff <= TIME_CLOSE_POS)
      else $error("time record index past close");

   a_can_index: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_CAN |-> index_ff <= CAN_CLOSE_POS)
      else $error("can record index past close");

   a_record_done: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.data.kind != KIND_RAW |=> mode_ff == MODE_TEXT)
      else $error("parser not back in text after a result");

endmodule

// ===== sv/eld_out_buf.sv =====
module eld_out_buf import eld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       push_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic    main_valid_ff, main_valid_in;
   rsp_type main_data_ff, main_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_fire;

   assign out_fire   = main_valid_ff && rsp_ready;
   assign push_ready = !skid_valid_ff;
   assign rsp_valid  = main_valid_ff;
   assign rsp_data   = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || out_fire) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = result.valid;
            main_data_in  = result.data;
         end
      end else if (result.valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds data while output is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> !skid_valid_ff)
      else $error("result pushed into full buffer");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_fire |=> main_valid_ff && main_data_ff == $past(skid_data_ff))
      else $error("skid entry lost on drain");

endmodule

// ===== sv/event_log_deframer.sv =====
// event log deframer
//
// req channel: one log byte per transaction (req_valid / req_ready), with
// stream_start marking the first byte of a new stream. rsp channel: zero or
// one result transaction per byte (rsp_valid / rsp_ready): a text or raw
// byte, a finished time or CAN record, or a framing error.
// csr channel: one write transaction sets decode_enable; write only while
// the block is idle. csr_ready is always high.
//
// throughput: one byte per cycle while req_ready is high; the parser state
// update and the result decode are combinational, and the accept edge
// registers each result into the output register or, when full, the skid.
//
// reset: parser back in text mode, decode_enable set, output buffer empty.
// stall: a two-entry output buffer (output register plus skid) keeps
// req_ready high while one result waits; req_ready drops only when both
// entries hold results, and bytes that give no result also wait then.
module event_log_deframer import eld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   // byte input
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   // result output
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload,
   // configuration write
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic       decode_enable_ff;
   logic       accept;
   logic       push_ready;
   result_type result;

   // configuration is always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         decode_enable_ff <= csr_data;
      end
   end

   // a byte is taken whenever the skid entry is free
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // byte parser and record state
   eld_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_data      (req_payload),
      .decode_enable (decode_enable_ff),
      .result        (result)
   );

   // output register with skid entry
   eld_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .push_ready (push_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_payload)
   );

endmodule

// ===== tb/event_log_deframer_tb.sv =====
module event_log_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import eld_pkg::*;

   localparam int RESET_CYCLES = 5;
   // cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT  = 2000;
   // the block registers each result when it accepts the byte, leave some margin
   localparam int SETTLE_CYCLES = 4;
   // long receiver hold-off, enough to fill the output buffer and stall input
   localparam int HOLD_CYCLES  = 300;
   // percent of cycles in which a side idles
   localparam int IDLE_PCT     = 32;

   // one line of the directed stimulus table
   typedef struct packed {
      req_type item;
      logic    typed;    // expected result written into the table
      logic    has_rsp;  // typed row gives a result
      rsp_type rsp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   // table info that travels alongside the byte on offer
   logic    row_typed = 1'b0;
   logic    row_has = 1'b0;
   rsp_type row_rsp = '0;

   // stimulus shaping
   logic    steady = 1'b0;
   logic    hold_off_req = 1'b0;
   int      hold_left = 0;
   logic    hold_seen = 1'b0;

   // deframer state as predicted by the testbench
   logic       decode_on = 1'b1;
   logic [1:0] parse_state = MODE_TEXT;
   logic [3:0] pos_in_record = '0;
   logic [7:0] src_hold = '0;
   logic [15:0] stamp_hold = '0;
   logic [15:0] id_hold = '0;
   logic [7:0] data_hold [8] = '{default: '0};
   logic [7:0] size_hold = '0;

   // results still owed by the block, oldest first
   rsp_type pending_results [$];
   rsp_type want;
   rsp_type guess;
   logic    guess_valid;

   stim_row_type directed [$];
   int      items_sent = 0;
   int      results_seen = 0;
   int      errors = 0;
   int      kind_count [8] = '{default: 0};
   int      quiet_cycles = 0;

   event_log_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type record_rsp(input logic [2:0] kind, input logic [7:0] text,
                                          input logic [7:0] src, input logic [15:0] stamp);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.text_byte = text;
      r.source_code = src;
      r.half_ms_count = stamp;
      return r;
   endfunction

   function automatic stim_row_type dir_row(input logic [7:0] b, input logic start,
                                            input logic typed, input logic has_rsp,
                                            input rsp_type rsp);
      stim_row_type s;
      s.item.log_byte = b;
      s.item.stream_start = start;
      s.typed = typed;
      s.has_rsp = has_rsp;
      s.rsp = rsp;
      return s;
   endfunction

   // next-state and result of the deframer for one accepted byte
   task automatic deframe_byte(input req_type r, output logic got, output rsp_type res);
      logic [3:0]  k;
      logic [63:0] pay;
      got = 1'b0;
      res = '0;
      // stream start drops any partial record, even with decoding off
      if (r.stream_start) begin
         parse_state = MODE_TEXT;
         pos_in_record = '0;
      end
      if (!decode_on) begin
         got = 1'b1;
         res.kind = KIND_RAW;
         res.text_byte = r.log_byte;
      end else begin
         case (parse_state)
            MODE_TEXT: begin
               pos_in_record = '0;
               // record openers give nothing, everything else is text
               if (r.log_byte == SOH_BYTE) begin
                  parse_state = MODE_CAN;
               end else if (r.log_byte == STX_BYTE) begin
                  parse_state = MODE_TIME;
               end else begin
                  got = 1'b1;
                  res.kind = KIND_TEXT;
                  res.text_byte = r.log_byte;
               end
            end
            MODE_TIME: begin
               k = pos_in_record;
               pos_in_record = pos_in_record + 4'd1;
               if (k == POS_FIRST) begin
                  src_hold = r.log_byte;
               end else if (k == POS_SECOND) begin
                  stamp_hold = {8'h00, r.log_byte};
               end else if (k == POS_THIRD) begin
                  stamp_hold = {stamp_hold[7:0], r.log_byte};
               end else begin
                  parse_state = MODE_TEXT;
                  got = 1'b1;
                  if (r.log_byte != ETX_BYTE) begin
                     res.kind = KIND_BAD_TIME;
                  end else begin
                     res.kind = KIND_TIME;
                     res.source_code = src_hold;
                     res.half_ms_count = stamp_hold;
                  end
               end
            end
            MODE_CAN: begin
               k = pos_in_record;
               pos_in_record = pos_in_record + 4'd1;
               if (k == POS_FIRST) begin
                  id_hold = {8'h00, r.log_byte};
               end else if (k == POS_SECOND) begin
                  id_hold = {id_hold[7:0], r.log_byte};
               end else if (k < CAN_SIZE_POS) begin
                  data_hold[3'(k - 4'd2)] = r.log_byte;
               end else if (k == CAN_SIZE_POS) begin
                  size_hold = r.log_byte;
               end else begin
                  parse_state = MODE_TEXT;
                  got = 1'b1;
                  if (r.log_byte != EOT_BYTE) begin
                     res.kind = KIND_BAD_CAN;
                  end else begin
                     pay = '0;
                     for (int j = 0; j < 8; j++) pay[8*j +: 8] = data_hold[j];
                     res.kind = KIND_CAN;
                     res.can_id = id_hold;
                     res.can_payload = pay;
                     res.can_length = size_hold;
                  end
               end
            end
            default: begin
               // unused mode swallows the byte
               parse_state = MODE_TEXT;
            end
         endcase
      end
   endtask

   task automatic report_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
      errors = errors + 1;
   endtask

   // scoreboard: check results first, then predict from the byte taken in the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen = results_seen + 1;
            kind_count[rsp_payload.kind] = kind_count[rsp_payload.kind] + 1;
            if (pending_results.size() == 0) begin
               $display("%0t ns: result with nothing expected, got %h", $time, rsp_payload);
               errors = errors + 1;
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.kind !== want.kind)
                  report_field("kind", 64'(want.kind), 64'(rsp_payload.kind));
               if (rsp_payload.text_byte !== want.text_byte)
                  report_field("text_byte", 64'(want.text_byte), 64'(rsp_payload.text_byte));
               if (rsp_payload.source_code !== want.source_code)
                  report_field("source_code", 64'(want.source_code),
                               64'(rsp_payload.source_code));
               if (rsp_payload.half_ms_count !== want.half_ms_count)
                  report_field("half_ms_count", 64'(want.half_ms_count),
                               64'(rsp_payload.half_ms_count));
               if (rsp_payload.can_id !== want.can_id)
                  report_field("can_id", 64'(want.can_id), 64'(rsp_payload.can_id));
               if (rsp_payload.can_payload !== want.can_payload)
                  report_field("can_payload", want.can_payload, rsp_payload.can_payload);
               if (rsp_payload.can_length !== want.can_length)
                  report_field("can_length", 64'(want.can_length), 64'(rsp_payload.can_length));
            end
         end
         if (req_valid && req_ready) begin
            deframe_byte(req_payload, guess_valid, guess);
            // table rows with a written-in answer override the prediction
            if (row_typed) begin
               guess_valid = row_has;
               guess = row_rsp;
            end
            if (guess_valid) pending_results.push_back(guess);
         end
         if (csr_valid && csr_ready) decode_on = csr_data;
      end
   end

   // receiver: random back-pressure, one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off_req && !hold_seen) begin
         rsp_ready <= 1'b0;
         hold_seen <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
      end
   end

   // watchdog: any transaction on any channel counts as progress
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("event_log_deframer verification failed");
            $finish;
         end
      end
   end

   // offer one byte, with random gaps, and wait for the transaction
   task automatic send_row(input req_type item, input logic typed, input logic has_rsp,
                           input rsp_type rsp);
      while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      row_typed <= typed;
      row_has <= has_rsp;
      row_rsp <= rsp;
      do @(posedge clock); while (!req_ready);
      items_sent = items_sent + 1;
   endtask

   task automatic put(input logic [7:0] b, input logic start);
      req_type r;
      r.log_byte = b;
      r.stream_start = start;
      send_row(r, 1'b0, 1'b0, '0);
   endtask

   // sender pauses until every owed result is back, then lets the block settle
   task automatic drain_results;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_decode_enable(input logic v);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one stretch of log: mostly whole records with random content, some noise
   task automatic send_random_unit;
      int         pick;
      logic [7:0] b;
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
         // well-formed time record
         put(STX_BYTE, $urandom_range(9, 0) == 0);
         repeat (3) put(8'($urandom_range(255, 0)), 1'b0);
         put(ETX_BYTE, 1'b0);
      end else if (pick < 60) begin
         // well-formed CAN record
         put(SOH_BYTE, $urandom_range(9, 0) == 0);
         repeat (11) put(8'($urandom_range(255, 0)), 1'b0);
         put(EOT_BYTE, 1'b0);
      end else if (pick < 70) begin
         // wrong closing byte
         b = 8'($urandom_range(255, 0));
         if ($urandom_range(1, 0)) begin
            put(STX_BYTE, 1'b0);
            repeat (3) put(8'($urandom_range(255, 0)), 1'b0);
            if (b == ETX_BYTE) b = ~b;
         end else begin
            put(SOH_BYTE, 1'b0);
            repeat (11) put(8'($urandom_range(255, 0)), 1'b0);
            if (b == EOT_BYTE) b = ~b;
         end
         put(b, 1'b0);
      end else if (pick < 78) begin
         // record opener, random bytes, then a new stream that may cut the record short
         put($urandom_range(1, 0) ? STX_BYTE : SOH_BYTE, 1'b0);
         repeat ($urandom_range(10, 0)) put(8'($urandom_range(255, 0)), 1'b0);
         put(8'($urandom_range(255, 0)), 1'b1);
      end else begin
         // loose text, may open stray records
         repeat ($urandom_range(6, 1))
            put(8'($urandom_range(255, 0)), $urandom_range(19, 0) == 0);
      end
   endtask

   task automatic run_random(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) send_random_unit();
   endtask

   initial begin
      // text extremes, one starting a stream
      directed.push_back(dir_row(8'h00, 1'b1, 1'b1, 1'b1,
                                 record_rsp(KIND_TEXT, 8'h00, 8'h00, 16'h0000)));
      directed.push_back(dir_row(8'hFF, 1'b0, 1'b1, 1'b1,
                                 record_rsp(KIND_TEXT, 8'hFF, 8'h00, 16'h0000)));
      directed.push_back(dir_row(EOT_BYTE, 1'b0, 1'b1, 1'b1,
                                 record_rsp(KIND_TEXT, EOT_BYTE, 8'h00, 16'h0000)));
      // time record with all-ones content
      directed.push_back(dir_row(STX_BYTE, 1'b0, 1'b1, 1'b0, '0));
      repeat (3) directed.push_back(dir_row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(ETX_BYTE, 1'b0, 1'b1, 1'b1,
                                 record_rsp(KIND_TIME, 8'h00, 8'hFF, 16'hFFFF)));
      // time record with a bad closing byte
      directed.push_back(dir_row(STX_BYTE, 1'b0, 1'b0, 1'b0, '0));
      repeat (3) directed.push_back(dir_row(8'h00, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(8'h7F, 1'b0, 1'b1, 1'b1,
                                 record_rsp(KIND_BAD_TIME, 8'h00, 8'h00, 16'h0000)));
      // stream start inside a CAN record, ETX in text
      directed.push_back(dir_row(SOH_BYTE, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(ETX_BYTE, 1'b1, 1'b1, 1'b1,
                                 record_rsp(KIND_TEXT, ETX_BYTE, 8'h00, 16'h0000)));
      // full CAN record, checked by the predictor
      directed.push_back(dir_row(SOH_BYTE, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(8'h00, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(8'h5A, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(8'hA5, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(SOH_BYTE, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(8'h80, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(STX_BYTE, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(8'h81, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(8'h08, 1'b0, 1'b0, 1'b0, '0));
      directed.push_back(dir_row(EOT_BYTE, 1'b0, 1'b0, 1'b0, '0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      write_decode_enable(1'b1);
      foreach (directed[i])
         send_row(directed[i].item, directed[i].typed, directed[i].has_rsp, directed[i].rsp);

      // long stretch with no idling on either side
      steady <= 1'b1;
      run_random(400);
      steady <= 1'b0;

      // raw pass-through, parser state carried over
      write_decode_enable(1'b0);
      run_random(150);

      // decoding again, receiver holds off once so the input stalls
      write_decode_enable(1'b1);
      hold_off_req <= 1'b1;
      run_random(400);

      write_decode_enable(1'b0);
      run_random(100);

      write_decode_enable(1'b1);
      run_random(400);

      drain_results();

      $display("%0d byte transactions, %0d results: text %0d, time %0d, can %0d,",
               items_sent, results_seen, kind_count[KIND_TEXT], kind_count[KIND_TIME],
               kind_count[KIND_CAN]);
      $display("bad time %0d, bad can %0d, raw %0d, decode toggled across five settings",
               kind_count[KIND_BAD_TIME], kind_count[KIND_BAD_CAN], kind_count[KIND_RAW]);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("event_log_deframer verification clean");
      end else begin
         $display("event_log_deframer verification failed");
      end
      $finish;
   end

endmodule
